// ----- hw/rtl/cgrm_pkg.sv -----
// shared types and constants of the chunk gain, resample and mix block
package cgrm_pkg;

  localparam logic signed [15:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;
  localparam logic [15:0] GAIN_UNITY  = 16'd16384;
  localparam logic [15:0] PITCH_UNITY = 16'd4096;
  localparam logic [12:0] WEIGHT_ONE  = 13'd4096;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // register index, taken from paddr[2]
  localparam logic REG_VOLUME_GAIN = 1'b0;
  localparam logic REG_PITCH_RATIO = 1'b1;

  typedef struct packed {
    logic signed [15:0] mic_sample;
    logic signed [15:0] pad_sample;
    logic               pad_valid;
    logic               chunk_last;
  } cgrm_in_t;

  typedef struct packed {
    logic signed [15:0] out_sample;
    logic               out_last;
    logic               chunk_overflow;
  } cgrm_out_t;

  typedef struct packed {
    logic load;
    logic tap_issue;
    logic tap_sel;
    logic out_load;
    logic advance;
    logic clear;
  } cgrm_cmd_t;

  typedef struct packed {
    logic res_vld;
    logic out_final;
  } cgrm_sts_t;

endpackage

// ----- hw/rtl/cgrm_ram.sv -----
// generic single write port, single read port ram with registered read
module cgrm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/cgrm_ctrl.sv -----
// controller state machine: load, tap issue, result wait and send
module cgrm_ctrl import cgrm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_last_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  cgrm_sts_t sts_i,
  output cgrm_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_TAP0,
    ST_TAP1,
    ST_WAIT,
    ST_SEND
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_LOAD: begin
          if (in_valid_i && in_last_i) begin
            state_q <= ST_TAP0;
          end
        end
        ST_TAP0: state_q <= ST_TAP1;
        ST_TAP1: state_q <= ST_WAIT;
        ST_WAIT: begin
          if (sts_i.res_vld) begin
            state_q     <= ST_SEND;
            out_valid_q <= 1'b1;
          end
        end
        ST_SEND: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            state_q     <= sts_i.out_final ? ST_LOAD : ST_TAP0;
          end
        end
        default: begin
          state_q     <= ST_LOAD;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_LOAD);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = (state_q == ST_LOAD) && in_valid_i;
    cmd_o.tap_issue = (state_q == ST_TAP0) || (state_q == ST_TAP1);
    cmd_o.tap_sel   = (state_q == ST_TAP1);
    cmd_o.out_load  = (state_q == ST_WAIT) && sts_i.res_vld;
    cmd_o.advance   = (state_q == ST_SEND) && !out_stall_i && !sts_i.out_final;
    cmd_o.clear     = (state_q == ST_SEND) && !out_stall_i && sts_i.out_final;
  end

  a_res_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.res_vld |-> state_q == ST_WAIT)
    else $error("result finished outside of wait state");

  a_valid_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q == (state_q == ST_SEND))
    else $error("output valid out of step with send state");

  a_no_load_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> !out_valid_q)
    else $error("input transfer while a result is pending");

endmodule

// ----- hw/rtl/cgrm_dpath.sv -----
// datapath: sample stores, counters, gain and interpolation pipeline, mix
module cgrm_dpath import cgrm_pkg::*; #(
  parameter int unsigned CHUNK_MAX = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cgrm_cmd_t   cmd_i,
  output cgrm_sts_t   sts_o,
  input  cgrm_in_t    in_data_i,
  input  logic [15:0] volume_gain_i,
  input  logic [15:0] pitch_ratio_i,
  output cgrm_out_t   out_data_o
);

  localparam int unsigned AW = $clog2(CHUNK_MAX);
  localparam int unsigned CW = $clog2(CHUNK_MAX + 1);
  localparam int unsigned PW = AW + 16;

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    logic signed [15:0] r;
    if (v > 20'(SAMPLE_MAX)) r = SAMPLE_MAX;
    else if (v < 20'(SAMPLE_MIN)) r = SAMPLE_MIN;
    else r = v[15:0];
    return r;
  endfunction

  // product / 16384 toward zero, saturated
  function automatic logic signed [15:0] gain_scale(input logic signed [32:0] p);
    logic signed [32:0] adj;
    logic signed [18:0] q;
    adj = p + (p[32] ? 33'sd16383 : 33'sd0);
    q   = $signed(adj[32:14]);
    return sat16(20'(q));
  endfunction

  // accumulator / 4096 toward zero, saturated
  function automatic logic signed [15:0] interp_scale(input logic signed [29:0] a);
    logic signed [29:0] adj;
    logic signed [17:0] q;
    adj = a + (a[29] ? 30'sd4095 : 30'sd0);
    q   = $signed(adj[29:12]);
    return sat16(20'(q));
  endfunction

  // {k, f} of the read point for one stream of length len
  function automatic logic [AW+11:0] tap_point(input logic [CW-1:0] len,
                                               input logic [PW-1:0] pos,
                                               input logic [CW-1:0] idx,
                                               input logic          unity);
    logic [CW-1:0]   last_idx;
    logic [PW-1:0]   lim;
    logic [AW+11:0]  r;
    last_idx = len - 1'b1;
    lim      = PW'(last_idx) << 12;
    if (unity) r = {idx[AW-1:0], 12'd0};
    else if (pos >= lim) r = {last_idx[AW-1:0], 12'd0};
    else r = pos[AW+11:0];
    return r;
  endfunction

  // counters and flags
  logic [CW-1:0] mic_cnt_q, pad_cnt_q, idx_q;
  logic [PW-1:0] pos_q;
  logic          ovf_q;

  logic          full, has_pad, mic_we, pad_we, unity;
  logic [CW-1:0] n_out;

  assign full    = (mic_cnt_q == CW'(CHUNK_MAX));
  assign has_pad = (pad_cnt_q != '0);
  assign mic_we  = cmd_i.load && !full;
  assign pad_we  = mic_we && in_data_i.pad_valid && (pad_cnt_q == mic_cnt_q);
  assign unity   = (pitch_ratio_i == PITCH_UNITY);
  assign n_out   = (has_pad && (pad_cnt_q < mic_cnt_q)) ? pad_cnt_q : mic_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mic_cnt_q <= '0;
      pad_cnt_q <= '0;
      idx_q     <= '0;
      pos_q     <= '0;
      ovf_q     <= 1'b0;
    end else if (cmd_i.clear) begin
      mic_cnt_q <= '0;
      pad_cnt_q <= '0;
      idx_q     <= '0;
      pos_q     <= '0;
      ovf_q     <= 1'b0;
    end else begin
      if (mic_we) mic_cnt_q <= mic_cnt_q + 1'b1;
      if (pad_we) pad_cnt_q <= pad_cnt_q + 1'b1;
      if (cmd_i.load && full) ovf_q <= 1'b1;
      if (cmd_i.advance) begin
        idx_q <= idx_q + 1'b1;
        pos_q <= pos_q + PW'(pitch_ratio_i);
      end
    end
  end

  // read points of both streams
  logic [AW+11:0] kf_m, kf_p;
  logic [AW-1:0]  k_m, k_p, raddr_m, raddr_p;
  logic [11:0]    f_m, f_p;
  logic [12:0]    w_m, w_p;

  assign kf_m    = tap_point(mic_cnt_q, pos_q, idx_q, unity);
  assign kf_p    = tap_point(pad_cnt_q, pos_q, idx_q, unity);
  assign k_m     = kf_m[AW+11:12];
  assign k_p     = kf_p[AW+11:12];
  assign f_m     = kf_m[11:0];
  assign f_p     = kf_p[11:0];
  assign raddr_m = cmd_i.tap_sel ? k_m + 1'b1 : k_m;
  assign raddr_p = cmd_i.tap_sel ? k_p + 1'b1 : k_p;
  assign w_m     = cmd_i.tap_sel ? {1'b0, f_m} : WEIGHT_ONE - {1'b0, f_m};
  assign w_p     = cmd_i.tap_sel ? {1'b0, f_p} : WEIGHT_ONE - {1'b0, f_p};

  logic [15:0] rd_m, rd_p;

  cgrm_ram #(.WIDTH(16), .DEPTH(CHUNK_MAX)) u_mic_ram (
    .clk_i   (clk_i),
    .we_i    (mic_we),
    .waddr_i (mic_cnt_q[AW-1:0]),
    .wdata_i (in_data_i.mic_sample),
    .raddr_i (raddr_m),
    .rdata_o (rd_m)
  );

  cgrm_ram #(.WIDTH(16), .DEPTH(CHUNK_MAX)) u_pad_ram (
    .clk_i   (clk_i),
    .we_i    (pad_we),
    .waddr_i (pad_cnt_q[AW-1:0]),
    .wdata_i (in_data_i.pad_sample),
    .raddr_i (raddr_p),
    .rdata_o (rd_p)
  );

  // pipeline control: ram read, gain product, gain scale, weight product, accumulate
  logic [3:0] vld_q, tap1_q;
  logic       fin_q, res_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      tap1_q    <= '0;
      fin_q     <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      vld_q     <= {vld_q[2:0], cmd_i.tap_issue};
      tap1_q    <= {tap1_q[2:0], cmd_i.tap_sel};
      fin_q     <= vld_q[3] && tap1_q[3];
      res_vld_q <= fin_q;
    end
  end

  logic [12:0]        wm_q [3];
  logic [12:0]        wp_q [3];
  logic signed [32:0] prod_m_q, prod_p_q;
  logic signed [15:0] g_m_q, g_p_q;
  logic signed [29:0] wprod_m_q, wprod_p_q;
  logic signed [29:0] acc_m_q, acc_p_q;
  logic signed [15:0] m_q, p_q;
  logic signed [16:0] mix_sum;
  cgrm_out_t          out_q;

  always_ff @(posedge clk_i) begin
    wm_q[0]  <= w_m;
    wp_q[0]  <= w_p;
    wm_q[1]  <= wm_q[0];
    wp_q[1]  <= wp_q[0];
    wm_q[2]  <= wm_q[1];
    wp_q[2]  <= wp_q[1];
    prod_m_q <= 33'($signed(rd_m)) * $signed({17'd0, volume_gain_i});
    prod_p_q <= 33'($signed(rd_p)) * $signed({17'd0, volume_gain_i});
    g_m_q    <= gain_scale(prod_m_q);
    g_p_q    <= gain_scale(prod_p_q);
    // a zero weight drops the tap, so an unused neighbor never leaks in
    wprod_m_q <= (wm_q[2] == '0) ? '0 : 30'(g_m_q) * $signed({17'd0, wm_q[2]});
    wprod_p_q <= (wp_q[2] == '0) ? '0 : 30'(g_p_q) * $signed({17'd0, wp_q[2]});
    if (vld_q[3]) begin
      acc_m_q <= tap1_q[3] ? acc_m_q + wprod_m_q : wprod_m_q;
      acc_p_q <= tap1_q[3] ? acc_p_q + wprod_p_q : wprod_p_q;
    end
    if (fin_q) begin
      m_q <= interp_scale(acc_m_q);
      p_q <= interp_scale(acc_p_q);
    end
    if (cmd_i.out_load) begin
      out_q.out_sample     <= has_pad ? sat16(20'(mix_sum)) : m_q;
      out_q.out_last       <= sts_o.out_final;
      out_q.chunk_overflow <= ovf_q;
    end
  end

  assign mix_sum = 17'(m_q) + 17'(p_q);

  assign sts_o.res_vld   = res_vld_q;
  assign sts_o.out_final = ((idx_q + 1'b1) == n_out);
  assign out_data_o      = out_q;

  a_pad_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pad_cnt_q <= mic_cnt_q)
    else $error("pad count ran ahead of mic count");

  a_tap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.tap_issue && !cmd_i.tap_sel) |->
      (CW'(k_m) < mic_cnt_q) && (!has_pad || (CW'(k_p) < pad_cnt_q)))
    else $error("first tap outside the stored chunk");

  a_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load && full && !cmd_i.clear) |=> ovf_q)
    else $error("dropped sample did not raise overflow");

endmodule

// ----- hw/rtl/chunk_gain_resample_mixer_core.sv -----
// top level of the chunk gain, resample and mix block
//
// input channel: one transfer per sample pair (mic sample, optional effects
// sample, pad_valid, chunk_last), one cycle each while loading. effects
// samples count only as an unbroken prefix of the chunk. samples beyond
// CHUNK_MAX are dropped and flag chunk_overflow on every result of the chunk.
// the transfer with chunk_last starts the emit run; in_stall_o stays high
// until the last result of the chunk has been taken.
// output channel: one result per output sample, out_last on the final one.
// each result is worked out after the previous output transfer (or after the
// chunk_last transfer for the first) from two ram taps per sample that go
// through the gain multiply, the weight multiply and the accumulator.
// a stalled receiver holds the result in the output register and the
// sequencer waits. reset: gain and pitch return to unity, counters and flags
// clear, the sample stores are not cleared. the user must write registers
// over apb only while idle; the block itself does not enforce it.
module chunk_gain_resample_mixer_core import cgrm_pkg::*; #(
  parameter int unsigned CHUNK_MAX = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // sample input
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  cgrm_in_t              in_data_i,
  // result output
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output cgrm_out_t             out_data_o,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  // configuration registers
  logic [15:0] volume_gain_q, pitch_ratio_q;
  logic        cfg_wr, reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volume_gain_q <= GAIN_UNITY;
      pitch_ratio_q <= PITCH_UNITY;
    end else if (cfg_wr) begin
      if (reg_sel == REG_VOLUME_GAIN) volume_gain_q <= pwdata[15:0];
      if (reg_sel == REG_PITCH_RATIO) pitch_ratio_q <= pwdata[15:0];
    end
  end

  // read back the selected register
  assign prdata = (reg_sel == REG_PITCH_RATIO) ? {16'd0, pitch_ratio_q}
                                               : {16'd0, volume_gain_q};

  // controller to datapath handshake
  cgrm_cmd_t cmd;
  cgrm_sts_t sts;

  cgrm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_data_i.chunk_last),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cgrm_dpath #(.CHUNK_MAX(CHUNK_MAX)) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_data_i     (in_data_i),
    .volume_gain_i (volume_gain_q),
    .pitch_ratio_i (pitch_ratio_q),
    .out_data_o    (out_data_o)
  );

endmodule

// ----- bench/testbench.sv -----
// self-checking testbench for the chunk gain, resample and mix block
module testbench;
  import cgrm_pkg::*;

  localparam int unsigned CHUNK_DEPTH   = 64;
  localparam int unsigned RANDOM_ITEMS  = 36;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned SETTLE_CYCLES = 24;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  // sample side
  logic      in_valid = 1'b0;
  logic      in_stall;
  cgrm_in_t  in_data  = '0;
  // result side
  logic      out_valid;
  logic      out_stall = 1'b0;
  cgrm_out_t out_data;
  // apb side
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [CFG_DATA_W-1:0] pwdata  = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  chunk_gain_resample_mixer_core #(
    .CHUNK_MAX(CHUNK_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #5 clk_i = ~clk_i;

  // mirror of the block state used for prediction
  logic [15:0]        gain_q  = GAIN_UNITY;
  logic [15:0]        pitch_q = PITCH_UNITY;
  logic signed [15:0] mic_hist  [CHUNK_DEPTH];
  logic signed [15:0] pad_hist  [CHUNK_DEPTH];
  logic signed [15:0] shape_mem [CHUNK_DEPTH];
  int unsigned        mic_fill = 0;
  int unsigned        pad_fill = 0;
  bit                 lost_items = 1'b0;
  cgrm_out_t          mix_expected [$];

  bit          idle_on = 1'b1;
  int unsigned stall_left = 0;
  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned chunks_sent = 0;
  int unsigned cfg_writes = 0;

  function automatic logic signed [15:0] clip16(input longint v);
    if (v > 32767) return SAMPLE_MAX;
    if (v < -32768) return SAMPLE_MIN;
    return v[15:0];
  endfunction

  // gain, truncate, saturate, then linear interpolation unless pitch is unity
  task automatic shape_stream(input int unsigned n);
    logic signed [15:0] interp [CHUNK_DEPTH];
    longint prod, acc, frac;
    int unsigned pos, k;
    for (int unsigned i = 0; i < n; i++) begin
      prod = longint'(shape_mem[i]) * longint'(gain_q);
      shape_mem[i] = clip16(prod / 16384);
    end
    if (pitch_q != PITCH_UNITY) begin
      for (int unsigned i = 0; i < n; i++) begin
        pos = i * pitch_q;
        if (pos >= ((n - 1) << 12)) begin
          interp[i] = shape_mem[n - 1];
        end else begin
          k    = pos >> 12;
          frac = pos & 4095;
          acc  = longint'(shape_mem[k]) * (4096 - frac) + longint'(shape_mem[k + 1]) * frac;
          interp[i] = clip16(acc / 4096);
        end
      end
      for (int unsigned i = 0; i < n; i++) shape_mem[i] = interp[i];
    end
  endtask

  task automatic predict_mix(input cgrm_in_t it);
    int unsigned n;
    cgrm_out_t res;
    if (mic_fill < CHUNK_DEPTH) begin
      // pad samples only count as an unbroken prefix
      if (it.pad_valid && pad_fill == mic_fill) begin
        pad_hist[pad_fill] = it.pad_sample;
        pad_fill++;
      end
      mic_hist[mic_fill] = it.mic_sample;
      mic_fill++;
    end else begin
      lost_items = 1'b1;
    end
    if (it.chunk_last) begin
      for (int unsigned i = 0; i < mic_fill; i++) shape_mem[i] = mic_hist[i];
      shape_stream(mic_fill);
      for (int unsigned i = 0; i < mic_fill; i++) mic_hist[i] = shape_mem[i];
      n = mic_fill;
      if (pad_fill > 0) begin
        for (int unsigned i = 0; i < pad_fill; i++) shape_mem[i] = pad_hist[i];
        shape_stream(pad_fill);
        if (pad_fill < n) n = pad_fill;
        for (int unsigned i = 0; i < n; i++)
          mic_hist[i] = clip16(longint'(mic_hist[i]) + longint'(shape_mem[i]));
      end
      for (int unsigned i = 0; i < n; i++) begin
        res.out_sample     = mic_hist[i];
        res.out_last       = (i + 1 == n);
        res.chunk_overflow = lost_items;
        mix_expected.push_back(res);
      end
      mic_fill   = 0;
      pad_fill   = 0;
      lost_items = 1'b0;
      chunks_sent++;
    end
  endtask

  // receiver: random stall bursts
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 15);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result checker: each transfer against the oldest expectation
  always @(posedge clk_i) begin : check_results
    cgrm_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (mix_expected.size() == 0) begin
        errors++;
        $display("%0t: unexpected result sample %0d last %0b ovf %0b", $time,
                 out_data.out_sample, out_data.out_last, out_data.chunk_overflow);
      end else begin
        want = mix_expected.pop_front();
        if (out_data !== want) begin
          errors++;
          $display("%0t: mismatch expected %0d last %0b ovf %0b, got %0d last %0b ovf %0b",
                   $time, want.out_sample, want.out_last, want.chunk_overflow,
                   out_data.out_sample, out_data.out_last, out_data.chunk_overflow);
        end
      end
    end
  end

  // one input transfer, with an optional gap before it
  task automatic send_item(input cgrm_in_t it);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk_i); while (in_stall);
    items_sent++;
    predict_mix(it);
  endtask

  function automatic cgrm_in_t make_item(input logic signed [15:0] mic,
                                         input logic signed [15:0] pad,
                                         input logic pv, input logic last);
    cgrm_in_t it;
    it.mic_sample = mic;
    it.pad_sample = pad;
    it.pad_valid  = pv;
    it.chunk_last = last;
    return it;
  endfunction

  // wait for every expected result, then let the block settle
  task automatic await_idle();
    in_valid <= 1'b0;
    while (mix_expected.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic idx, input logic [15:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0000, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    if (idx == REG_VOLUME_GAIN) gain_q = val;
    else pitch_q = val;
    cfg_writes++;
  endtask

  task automatic cfg_check(input logic idx, input logic [15:0] want);
    logic [CFG_DATA_W-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    if (got !== {16'h0000, want}) begin
      errors++;
      $display("%0t: register %0d readback expected %0d, got %0d", $time, idx, want, got);
    end
  endtask

  task automatic set_config(input logic [15:0] gain, input logic [15:0] pitch);
    cfg_write(REG_VOLUME_GAIN, gain);
    cfg_write(REG_PITCH_RATIO, pitch);
    cfg_check(REG_VOLUME_GAIN, gain);
    cfg_check(REG_PITCH_RATIO, pitch);
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 15))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return 16'sd0;
      3:       return -16'sd1;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // a chunk of random length and pad pattern
  task automatic send_random_chunk(output int unsigned len);
    int unsigned sel, mode, prefix;
    cgrm_in_t it;
    sel = $urandom_range(0, 19);
    if (sel < 14) len = $urandom_range(1, 8);
    else if (sel < 19) len = $urandom_range(9, 24);
    else len = $urandom_range(25, CHUNK_DEPTH);
    mode   = $urandom_range(0, 3);
    prefix = $urandom_range(0, len);
    for (int unsigned i = 0; i < len; i++) begin
      it.mic_sample = pick_sample();
      it.pad_sample = pick_sample();
      case (mode)
        0:       it.pad_valid = 1'b0;
        1:       it.pad_valid = 1'b1;
        2:       it.pad_valid = (i < prefix);
        default: it.pad_valid = 1'($urandom_range(0, 1));
      endcase
      it.chunk_last = (i + 1 == len);
      send_item(it);
    end
  endtask

  task automatic test_register_defaults();
    cfg_check(REG_VOLUME_GAIN, GAIN_UNITY);
    cfg_check(REG_PITCH_RATIO, PITCH_UNITY);
  endtask

  // unity gain and pitch, mic only: extremes pass straight through
  task automatic test_unity_passthrough();
    send_item(make_item(SAMPLE_MAX, 16'sd0, 1'b0, 1'b0));
    send_item(make_item(SAMPLE_MIN, 16'sd0, 1'b0, 1'b0));
    send_item(make_item(16'sd0, 16'sd0, 1'b0, 1'b1));
    await_idle();
  endtask

  // mix saturates both ways; a shorter pad stream shortens the output
  task automatic test_mix_saturation();
    send_item(make_item(SAMPLE_MAX, SAMPLE_MAX, 1'b1, 1'b0));
    send_item(make_item(SAMPLE_MIN, SAMPLE_MIN, 1'b1, 1'b1));
    send_item(make_item(16'sd1200, -16'sd300, 1'b1, 1'b0));
    send_item(make_item(-16'sd5, 16'sd77, 1'b0, 1'b0));
    send_item(make_item(16'sd9, 16'sd11, 1'b0, 1'b1));
    await_idle();
  endtask

  // a valid pad sample after an invalid one is ignored
  task automatic test_pad_gap();
    send_item(make_item(16'sd100, 16'sd1000, 1'b1, 1'b0));
    send_item(make_item(16'sd200, 16'sd2000, 1'b0, 1'b0));
    send_item(make_item(16'sd300, 16'sd3000, 1'b1, 1'b0));
    send_item(make_item(16'sd400, 16'sd4000, 1'b1, 1'b1));
    await_idle();
  endtask

  task automatic test_gain_extremes();
    set_config(16'd0, PITCH_UNITY);
    send_item(make_item(SAMPLE_MAX, SAMPLE_MIN, 1'b1, 1'b0));
    send_item(make_item(-16'sd1, 16'sd1, 1'b1, 1'b1));
    await_idle();
    set_config(16'hffff, PITCH_UNITY);
    send_item(make_item(SAMPLE_MAX, -16'sd3, 1'b1, 1'b0));
    send_item(make_item(SAMPLE_MIN, 16'sd12345, 1'b0, 1'b1));
    await_idle();
  endtask

  // zero, maximum and fractional pitch, plus a one-sample chunk
  task automatic test_pitch_cases();
    set_config(GAIN_UNITY, 16'd0);
    send_item(make_item(16'sd500, -16'sd700, 1'b1, 1'b0));
    send_item(make_item(16'sd600, 16'sd800, 1'b1, 1'b0));
    send_item(make_item(16'sd700, 16'sd900, 1'b1, 1'b1));
    await_idle();
    set_config(GAIN_UNITY, 16'hffff);
    send_item(make_item(16'sd10, 16'sd0, 1'b0, 1'b0));
    send_item(make_item(16'sd20, 16'sd0, 1'b0, 1'b0));
    send_item(make_item(16'sd30, 16'sd0, 1'b0, 1'b1));
    await_idle();
    set_config(16'd20000, 16'd2048);
    send_item(make_item(SAMPLE_MAX, 16'sd4000, 1'b1, 1'b0));
    send_item(make_item(SAMPLE_MIN, -16'sd4001, 1'b1, 1'b0));
    send_item(make_item(16'sd31000, 16'sd3, 1'b0, 1'b0));
    send_item(make_item(-16'sd31000, 16'sd5, 1'b0, 1'b1));
    await_idle();
    set_config(GAIN_UNITY, 16'd6144);
    send_item(make_item(-16'sd1234, 16'sd4321, 1'b1, 1'b1));
    await_idle();
  endtask

  // beyond capacity: dropped items flag the chunk, the flag clears after
  task automatic test_chunk_overflow();
    set_config(16'd12000, 16'd3000);
    for (int unsigned i = 0; i < CHUNK_DEPTH + 2; i++)
      send_item(make_item(pick_sample(), pick_sample(), 1'b1, i == CHUNK_DEPTH + 1));
    await_idle();
    send_item(make_item(16'sd42, -16'sd42, 1'b0, 1'b0));
    send_item(make_item(16'sd43, -16'sd43, 1'b1, 1'b1));
    await_idle();
  endtask

  task automatic test_random_chunks();
    int unsigned phase_items, len, sel;
    logic [15:0] gain, pitch;
    for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
      sel = $urandom_range(0, 4);
      gain = (sel == 0) ? 16'd0 : (sel == 1) ? 16'hffff : (sel == 2) ? GAIN_UNITY :
             16'($urandom_range(0, 65535));
      sel = $urandom_range(0, 4);
      pitch = (sel == 0) ? 16'd0 : (sel == 1) ? 16'hffff : (sel == 2) ? PITCH_UNITY :
              (sel == 3) ? 16'($urandom_range(1, 8191)) : 16'($urandom_range(0, 65535));
      set_config(gain, pitch);
      // the closing stretch runs with no idling on either side
      if (ph == RANDOM_PHASES - 1) idle_on = 1'b0;
      phase_items = 0;
      while (phase_items < RANDOM_ITEMS / RANDOM_PHASES) begin
        send_random_chunk(len);
        phase_items += len;
      end
      await_idle();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    test_register_defaults();
    test_unity_passthrough();
    test_mix_saturation();
    test_pad_gap();
    test_gain_extremes();
    test_pitch_cases();
    test_chunk_overflow();
    test_random_chunks();
    await_idle();
    $display("covered %0d chunks: %0d sample transfers in, %0d result transfers out,",
             chunks_sent, items_sent, results_seen);
    $display("%0d register writes across gain and pitch extremes, %0d errors",
             cfg_writes, errors);
    if (errors == 0) begin
      $display("PASS chunk_gain_resample_mixer_core");
    end else begin
      $display("FAIL chunk_gain_resample_mixer_core");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("timeout with %0d results outstanding", mix_expected.size());
    $display("FAIL chunk_gain_resample_mixer_core");
    $finish;
  end

endmodule

// ----- chunk_gain_resample_mixer_core.f -----
hw/rtl/cgrm_pkg.sv
hw/rtl/cgrm_ram.sv
hw/rtl/cgrm_ctrl.sv
hw/rtl/cgrm_dpath.sv
hw/rtl/chunk_gain_resample_mixer_core.sv
bench/testbench.sv
